FILE: rtl/core/hbst_pkg.sv
// Package for the hashed best-score table.
// Holds the entry record, hash constants, step codes and the control FSM type.
// No dependencies.
package hbst_pkg;

   localparam int unsigned SLOTS_DEFAULT = 32;

   localparam int unsigned HASH_W  = 16;
   localparam int unsigned KEY_W   = 16;
   localparam int unsigned LEVEL_W = 3;
   localparam int unsigned SCORE_W = 32;
   localparam int unsigned COMBO_W = 16;
   localparam int unsigned MASK_W  = 8;
   localparam int unsigned TOTAL_W = 32;

   localparam logic [HASH_W-1:0] HASH_SEED = 16'h811c;
   localparam logic [HASH_W-1:0] HASH_MULT = 16'h9101;

   // hash sequencer: three multiply rounds, a reciprocal quotient, a multiply-back remainder
   localparam int unsigned STEP_W = 3;
   localparam logic [STEP_W-1:0] ROUND_KEY_LO = 3'd0;
   localparam logic [STEP_W-1:0] ROUND_KEY_HI = 3'd1;
   localparam logic [STEP_W-1:0] ROUND_LEVEL  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_QUOT    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_REM     = 3'd4;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic [HASH_W-1:0]  tag;
      logic [LEVEL_W-1:0] level;
      logic [SCORE_W-1:0] score;
      logic [COMBO_W-1:0] combo;
      logic [MASK_W-1:0]  cleared;
   } entry_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] hash;
   } hash_res_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_UPDATE
   } state_type;

endpackage

FILE: rtl/core/hbst_hash.sv
// Iterative key hash and slot reduction for the hashed best-score table.
// One 16x16 multiplier runs three hash rounds, then a reciprocal multiply and a
// multiply-back with one correcting subtract form hash mod SLOTS. Uses hbst_pkg.
module hbst_hash #(
   parameter int unsigned SLOTS = hbst_pkg::SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [hbst_pkg::KEY_W-1:0]         key_index,
   input  logic [hbst_pkg::LEVEL_W-1:0]       level,
   output hbst_pkg::hash_res_type             res,
   output logic [$clog2(SLOTS)-1:0]           slot
);

   localparam int unsigned SLOT_W = $clog2(SLOTS);
   // floor(2^16 / SLOTS): the quotient estimate is low by at most one
   localparam logic [hbst_pkg::HASH_W-1:0] RECIP   = 16'(65536 / SLOTS);
   localparam logic [hbst_pkg::HASH_W-1:0] SLOTS_H = 16'(SLOTS);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [hbst_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [hbst_pkg::HASH_W-1:0]   hash_ff, hash_in;
   logic [hbst_pkg::HASH_W-1:0]   quot_ff, quot_in;
   logic [SLOT_W-1:0]             rem_ff, rem_in;

   logic [7:0]                    mix_byte;
   logic [hbst_pkg::HASH_W-1:0]   mul_a;
   logic [hbst_pkg::HASH_W-1:0]   mul_b;
   logic [2*hbst_pkg::HASH_W-1:0] product;
   logic [hbst_pkg::HASH_W-1:0]   mixed;
   logic [hbst_pkg::HASH_W-1:0]   diff;

   always_comb begin
      case (step_ff)
         hbst_pkg::ROUND_KEY_LO: begin
            mix_byte = key_index[7:0];
         end
         hbst_pkg::ROUND_KEY_HI: begin
            mix_byte = key_index[15:8];
         end
         default: begin
            mix_byte = {5'b0, level};
         end
      endcase

      // shared multiplier operands
      case (step_ff)
         hbst_pkg::STEP_QUOT: begin
            mul_a = hash_ff;
            mul_b = RECIP;
         end
         hbst_pkg::STEP_REM: begin
            mul_a = quot_ff;
            mul_b = SLOTS_H;
         end
         default: begin
            mul_a = hash_ff ^ {8'b0, mix_byte};
            mul_b = hbst_pkg::HASH_MULT;
         end
      endcase

      product = {16'b0, mul_a} * {16'b0, mul_b};
      mixed   = product[hbst_pkg::HASH_W-1:0];

      // hash - quot*SLOTS stays below 2*SLOTS
      diff = hash_ff - product[hbst_pkg::HASH_W-1:0];
      if (diff >= SLOTS_H) begin
         diff = diff - SLOTS_H;
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      hash_in = hash_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         hash_in = hbst_pkg::HASH_SEED;
         rem_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         case (step_ff)
            hbst_pkg::ROUND_LEVEL: begin
               // zero is reserved for empty entries
               if (mixed == '0) begin
                  hash_in = 16'd1;
               end else begin
                  hash_in = mixed;
               end
            end
            hbst_pkg::STEP_QUOT: begin
               quot_in = product[2*hbst_pkg::HASH_W-1:hbst_pkg::HASH_W];
            end
            hbst_pkg::STEP_REM: begin
               rem_in  = diff[SLOT_W-1:0];
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: begin
               hash_in = mixed;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign res.done = done_ff;
   assign res.hash = hash_ff;
   assign slot     = rem_ff;

endmodule

FILE: rtl/core/hbst_table.sv
// Direct-mapped entry store for the hashed best-score table.
// One write port, one registered read port, per-entry valid bits cleared
// by reset; an invalid entry reads as all zero. Uses hbst_pkg.
module hbst_table #(
   parameter int unsigned SLOTS = hbst_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [$clog2(SLOTS)-1:0]    wr_addr,
   input  hbst_pkg::entry_type         wr_entry,
   input  logic [$clog2(SLOTS)-1:0]    rd_addr,
   output hbst_pkg::entry_type         rd_entry
);

   hbst_pkg::entry_type mem [SLOTS];
   hbst_pkg::entry_type rd_data_ff;
   logic [SLOTS-1:0]    valid_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/core/hashed_best_score_table.sv
// Hashed best-score table: a direct-mapped store of per-key best results,
// indexed by a 16-bit FNV-style hash of the key's two low bytes and level
// (a zero hash becomes one), taken mod SLOTS. A record (tuser 0) evicts a
// non-matching entry, keeps the max score and combo, ORs the level's cleared
// bit and bumps the wrapping play and score totals; a lookup (tuser 1)
// returns the entry only on a tag and level match. One item is in flight at
// a time and passes through the idle, hash, read and update states. The hash
// state covers the shared 16x16 multiplier (three hash rounds, a reciprocal
// multiply for the quotient, a multiply-back for the remainder with one
// correcting subtract) and the sequencer seeing the hash; then come the table
// read and the update, and the idle state takes the next transfer. The result
// sits in an output register, so a new request can be taken while it waits;
// that request then holds in the read state until the waiting result is
// taken. The table valid bits are cleared in the reset cycle; no sweep.
module hashed_best_score_table #(
   parameter int unsigned SLOTS = hbst_pkg::SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // command (0 record, 1 lookup)
   input  logic [71:0]  req_tdata,   // key_index[15:0], level[18:16],
                                     // new_score[50:19], new_combo[66:51],
                                     // was_cleared[67], zero pad [71:68]

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,   // hit
   output logic [119:0] rsp_tdata    // top_score[31:0], top_combo[47:32],
                                     // cleared_mask[55:48], play_count[87:56],
                                     // score_sum[119:88]
);

   localparam int unsigned SLOT_W = $clog2(SLOTS);

   hbst_pkg::state_type state_ff, state_in;

   // captured request
   logic                           cmd_ff;
   logic [hbst_pkg::KEY_W-1:0]     key_ff;
   logic [hbst_pkg::LEVEL_W-1:0]   level_ff;
   logic [hbst_pkg::SCORE_W-1:0]   score_ff;
   logic [hbst_pkg::COMBO_W-1:0]   combo_ff;
   logic                           clr_ff;

   // running totals
   logic [hbst_pkg::TOTAL_W-1:0]   plays_ff, plays_in;
   logic [hbst_pkg::TOTAL_W-1:0]   sums_ff, sums_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff, rsp_hit_in;
   hbst_pkg::entry_type            rsp_entry_ff, rsp_entry_in;

   logic                           req_accept;
   logic                           rsp_load;
   logic                           tbl_wr_en;
   hbst_pkg::hash_res_type         hash_res;
   logic [SLOT_W-1:0]              slot;
   hbst_pkg::entry_type            rd_entry;
   hbst_pkg::entry_type            base_entry;
   hbst_pkg::entry_type            new_entry;
   logic                           match;
   logic                           is_record;

   assign req_tready = (state_ff == hbst_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign is_record  = (cmd_ff == hbst_pkg::CMD_RECORD);

   hbst_hash #(
      .SLOTS(SLOTS)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .key_index (key_ff),
      .level     (level_ff),
      .res       (hash_res),
      .slot      (slot)
   );

   hbst_table #(
      .SLOTS(SLOTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (slot),
      .wr_entry (new_entry),
      .rd_addr  (slot),
      .rd_entry (rd_entry)
   );

   // entry update: a miss on record starts from a fresh entry for this key
   always_comb begin
      match = (rd_entry.tag == hash_res.hash) && (rd_entry.level == level_ff);

      if (match) begin
         base_entry = rd_entry;
      end else begin
         base_entry         = '0;
         base_entry.tag     = hash_res.hash;
         base_entry.level   = level_ff;
      end

      new_entry = base_entry;
      if (score_ff > base_entry.score) begin
         new_entry.score = score_ff;
      end
      if (combo_ff > base_entry.combo) begin
         new_entry.combo = combo_ff;
      end
      if (clr_ff) begin
         new_entry.cleared = base_entry.cleared | (8'd1 << level_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tbl_wr_en    = 1'b0;
      rsp_load     = 1'b0;
      plays_in     = plays_ff;
      sums_in      = sums_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_entry_in = rsp_entry_ff;

      case (state_ff)
         hbst_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = hbst_pkg::ST_HASH;
            end
         end
         hbst_pkg::ST_HASH: begin
            if (hash_res.done) begin
               state_in = hbst_pkg::ST_READ;
            end
         end
         hbst_pkg::ST_READ: begin
            // table re-reads the same slot while the output is occupied
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = hbst_pkg::ST_UPDATE;
            end
         end
         hbst_pkg::ST_UPDATE: begin
            rsp_load = 1'b1;
            state_in = hbst_pkg::ST_IDLE;
            if (is_record) begin
               tbl_wr_en    = 1'b1;
               plays_in     = plays_ff + 1'b1;
               sums_in      = sums_ff + score_ff;
               rsp_hit_in   = 1'b1;
               rsp_entry_in = new_entry;
            end else begin
               rsp_hit_in   = match;
               rsp_entry_in = match ? rd_entry : '0;
            end
         end
         default: begin
            state_in = hbst_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbst_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         plays_ff     <= '0;
         sums_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         plays_ff     <= plays_in;
         sums_ff      <= sums_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_tuser;
         key_ff   <= req_tdata[15:0];
         level_ff <= req_tdata[18:16];
         score_ff <= req_tdata[50:19];
         combo_ff <= req_tdata[66:51];
         clr_ff   <= req_tdata[67];
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_entry_ff <= rsp_entry_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {sums_ff, plays_ff, rsp_entry_ff.cleared,
                        rsp_entry_ff.combo, rsp_entry_ff.score};

`ifndef NO_ASSERTIONS
   // a new result only ever comes out of the update cycle
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == hbst_pkg::ST_UPDATE))
      else $error("result appeared outside the update cycle");

   // hash unit finishes only while the sequencer waits for it
   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_res.done |-> (state_ff == hbst_pkg::ST_HASH))
      else $error("hash completion outside hash wait");

   // play total moves only on a record update
   a_plays_on_record: assert property (@(posedge clock) disable iff (reset)
      (plays_ff != $past(plays_ff)) |->
         $past(state_ff == hbst_pkg::ST_UPDATE && is_record))
      else $error("play total changed without a record");

   // a record always reports a hit
   a_record_hits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hbst_pkg::ST_UPDATE && is_record) |=> (rsp_tvalid && rsp_tuser))
      else $error("record result without hit");
`endif

endmodule

FILE: dv/tb_hashed_best_score_table.sv
// Self-checking testbench for the hashed best-score table: directed rows, then random traffic
// under several idle and backpressure patterns, each result checked against a local model or
// a hand-written expectation. Depends on hbst_pkg and hashed_best_score_table.
module tb_hashed_best_score_table;

   localparam int unsigned NUM_SLOTS      = hbst_pkg::SLOTS_DEFAULT;
   localparam int unsigned CLK_HALF       = 5;
   localparam int unsigned TIMEOUT_CYC    = 1_000_000;
   localparam int unsigned HOLD_CYCLES    = 300;   // long output hold under pressure
   localparam int unsigned DRAIN_CYC      = 60;    // settling time after the last result
   localparam int unsigned POOL_SIZE      = 40;    // working set of keys, > slots so keys collide
   localparam int unsigned PHASE_ITEMS    = 300;
   localparam int unsigned PRESSURE_ITEMS = 24;
   localparam int unsigned TAIL_ITEMS     = 104;

   typedef struct packed {
      logic                         cmd;
      logic [hbst_pkg::KEY_W-1:0]   key;
      logic [hbst_pkg::LEVEL_W-1:0] level;
      logic [hbst_pkg::SCORE_W-1:0] score;
      logic [hbst_pkg::COMBO_W-1:0] combo;
      logic                         cleared;
   } score_request_type;

   typedef struct packed {
      logic                         hit;
      logic [hbst_pkg::SCORE_W-1:0] top_score;
      logic [hbst_pkg::COMBO_W-1:0] top_combo;
      logic [hbst_pkg::MASK_W-1:0]  cleared_mask;
      logic [hbst_pkg::TOTAL_W-1:0] play_count;
      logic [hbst_pkg::TOTAL_W-1:0] score_sum;
   } score_result_type;

   // one directed row; 'typed' rows carry a hand-written expectation
   typedef struct packed {
      score_request_type req;
      logic              typed;
      score_result_type  want;
   } directed_row_type;

   // ---------------------------------------------------------------- DUT ports
   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser  = 1'b0;  // command
   logic [71:0]  req_tdata  = '0;    // key_index, level, new_score, new_combo, was_cleared, pad
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         rsp_tuser;          // hit
   logic [119:0] rsp_tdata;          // top_score, top_combo, cleared_mask, play_count,
                                     // score_sum

   hashed_best_score_table #(
      .SLOTS(NUM_SLOTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------- table model
   logic [hbst_pkg::HASH_W-1:0]  model_tag     [NUM_SLOTS];
   logic [hbst_pkg::LEVEL_W-1:0] model_level   [NUM_SLOTS];
   logic [hbst_pkg::SCORE_W-1:0] model_score   [NUM_SLOTS];
   logic [hbst_pkg::COMBO_W-1:0] model_combo   [NUM_SLOTS];
   logic [hbst_pkg::MASK_W-1:0]  model_cleared [NUM_SLOTS];
   logic [hbst_pkg::TOTAL_W-1:0] model_plays;
   logic [hbst_pkg::TOTAL_W-1:0] model_sum;

   score_result_type pending_results[$];   // expected results, oldest first
   directed_row_type directed_rows[$];

   // random working set of keys
   logic [hbst_pkg::KEY_W-1:0]   pool_key   [POOL_SIZE];
   logic [hbst_pkg::LEVEL_W-1:0] pool_level [POOL_SIZE];

   int unsigned req_idle_pct  = 0;   // chance per cycle that the sender holds back
   int unsigned rsp_stall_pct = 0;   // chance per cycle that the receiver stalls
   logic        hold_request  = 1'b0;

   int unsigned records_sent    = 0;
   int unsigned lookups_sent    = 0;
   int unsigned lookup_hits     = 0;
   int unsigned results_checked = 0;
   int unsigned fail_count      = 0;

   // 16-bit FNV-1a-style hash over key low byte, key high byte, level; no zero fix-up here
   function automatic logic [hbst_pkg::HASH_W-1:0] fnv_raw(
      input logic [hbst_pkg::KEY_W-1:0] key,
      input logic [hbst_pkg::LEVEL_W-1:0] level);
      logic [hbst_pkg::HASH_W-1:0] h;
      h = hbst_pkg::HASH_SEED;
      h = (h ^ {8'h00, key[7:0]}) * hbst_pkg::HASH_MULT;
      h = (h ^ {8'h00, key[15:8]}) * hbst_pkg::HASH_MULT;
      h = (h ^ {13'h0000, level}) * hbst_pkg::HASH_MULT;
      return h;
   endfunction

   // Applies one command to the model table and returns the result it yields.
   function automatic score_result_type apply_table_access(input score_request_type rq);
      logic [hbst_pkg::HASH_W-1:0] h;
      int unsigned                 slot;
      logic                        match;
      score_result_type            res;
      h = fnv_raw(rq.key, rq.level);
      if (h == '0) h = 16'd1;   // zero is reserved for empty entries
      slot  = h % NUM_SLOTS;
      match = (model_tag[slot] == h) && (model_level[slot] == rq.level);
      if (rq.cmd == hbst_pkg::CMD_RECORD) begin
         if (!match) begin
            // evict whatever lived here
            model_tag[slot]     = h;
            model_level[slot]   = rq.level;
            model_score[slot]   = '0;
            model_combo[slot]   = '0;
            model_cleared[slot] = '0;
         end
         if (rq.score > model_score[slot]) model_score[slot] = rq.score;
         if (rq.combo > model_combo[slot]) model_combo[slot] = rq.combo;
         if (rq.cleared) model_cleared[slot] = model_cleared[slot] | (8'h01 << rq.level);
         model_plays = model_plays + 32'd1;
         model_sum   = model_sum + rq.score;
         match       = 1'b1;
      end
      res.hit          = match;
      res.top_score    = match ? model_score[slot] : '0;
      res.top_combo    = match ? model_combo[slot] : '0;
      res.cleared_mask = match ? model_cleared[slot] : '0;
      res.play_count   = model_plays;
      res.score_sum    = model_sum;
      return res;
   endfunction

   function automatic score_request_type mk_req(input logic cmd, input logic [15:0] key,
                                                input logic [2:0] level,
                                                input logic [31:0] score,
                                                input logic [15:0] combo,
                                                input logic cleared);
      score_request_type rq;
      rq.cmd     = cmd;
      rq.key     = key;
      rq.level   = level;
      rq.score   = score;
      rq.combo   = combo;
      rq.cleared = cleared;
      return rq;
   endfunction

   function automatic score_result_type mk_res(input logic hit, input logic [31:0] top_score,
                                               input logic [15:0] top_combo,
                                               input logic [7:0] cleared_mask,
                                               input logic [31:0] play_count,
                                               input logic [31:0] score_sum);
      score_result_type r;
      r.hit          = hit;
      r.top_score    = top_score;
      r.top_combo    = top_combo;
      r.cleared_mask = cleared_mask;
      r.play_count   = play_count;
      r.score_sum    = score_sum;
      return r;
   endfunction

   task automatic row(input score_request_type rq, input logic typed,
                      input score_result_type want);
      directed_row_type d;
      d.req   = rq;
      d.typed = typed;
      d.want  = want;
      directed_rows.push_back(d);
   endtask

   // Mostly keys from the working set so records and lookups meet; some strays and level
   // swaps to force misses and evictions. Scores and combos lean toward both extremes.
   function automatic score_request_type random_request();
      score_request_type rq;
      int unsigned       pick;
      pick = $urandom_range(POOL_SIZE - 1);
      if ($urandom_range(99) < 5) begin
         pool_key[pick]   = 16'($urandom);
         pool_level[pick] = 3'($urandom);
      end
      if ($urandom_range(99) < 80) begin
         rq.key   = pool_key[pick];
         rq.level = pool_level[pick];
      end else begin
         rq.key   = 16'($urandom);
         rq.level = 3'($urandom);
      end
      if ($urandom_range(99) < 15) rq.level = 3'($urandom);
      rq.cmd = ($urandom_range(99) < 55) ? hbst_pkg::CMD_RECORD : hbst_pkg::CMD_LOOKUP;
      case ($urandom_range(3))
         0: rq.score = $urandom_range(255);
         1: rq.score = 32'hffff_ffff - $urandom_range(255);
         default: rq.score = $urandom;
      endcase
      case ($urandom_range(3))
         0: rq.combo = 16'($urandom_range(63));
         1: rq.combo = 16'(16'hffff - $urandom_range(63));
         default: rq.combo = 16'($urandom);
      endcase
      rq.cleared = 1'($urandom);
      return rq;
   endfunction

   // Offers one transfer on the request side, changing inputs at the falling edge.
   // Valid stays high after acceptance; the next call (or idle_and_drain) settles it.
   task automatic send_request(input score_request_type rq, input logic typed,
                               input score_result_type want);
      score_result_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= rq.cmd;
      req_tdata  <= {4'h0, rq.cleared, rq.combo, rq.score, rq.level, rq.key};
      do @(posedge clock); while (!req_tready);
      predicted = apply_table_access(rq);
      pending_results.push_back(typed ? want : predicted);
      if (rq.cmd == hbst_pkg::CMD_RECORD) begin
         records_sent++;
      end else begin
         lookups_sent++;
         if (predicted.hit) lookup_hits++;
      end
   endtask

   // Stops offering and waits for every outstanding result.
   task automatic idle_and_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------- receiver
   // Random stalls per rsp_stall_pct; on request, a long hold counted here.
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------- result checker
   always @(posedge clock) begin
      score_result_type seen;
      score_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.hit          = rsp_tuser;
         seen.top_score    = rsp_tdata[31:0];
         seen.top_combo    = rsp_tdata[47:32];
         seen.cleared_mask = rsp_tdata[55:48];
         seen.play_count   = rsp_tdata[87:56];
         seen.score_sum    = rsp_tdata[119:88];
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: expected none, got %h", $time, seen);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            compare_field("hit",          want.hit,          seen.hit);
            compare_field("top_score",    want.top_score,    seen.top_score);
            compare_field("top_combo",    want.top_combo,    seen.top_combo);
            compare_field("cleared_mask", want.cleared_mask, seen.cleared_mask);
            compare_field("play_count",   want.play_count,   seen.play_count);
            compare_field("score_sum",    want.score_sum,    seen.score_sum);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      logic [hbst_pkg::KEY_W-1:0]   zero_key;
      logic [hbst_pkg::LEVEL_W-1:0] zero_lvl;
      logic [hbst_pkg::KEY_W-1:0]   one_key;
      logic [hbst_pkg::KEY_W-1:0]   collide_key;
      logic [hbst_pkg::HASH_W-1:0]  base_hash;
      logic [hbst_pkg::HASH_W-1:0]  h;
      logic                         found;

      for (int s = 0; s < NUM_SLOTS; s++) begin
         model_tag[s]     = '0;
         model_level[s]   = '0;
         model_score[s]   = '0;
         model_combo[s]   = '0;
         model_cleared[s] = '0;
      end
      model_plays = '0;
      model_sum   = '0;
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_key[p]   = 16'($urandom);
         pool_level[p] = 3'($urandom);
      end

      // key whose raw hash is zero (stored as one), and a key hashing to one at that level,
      // which must then share the entry
      zero_key = '0;
      zero_lvl = '0;
      one_key  = '0;
      found    = 1'b0;
      for (int l = 0; l < 8 && !found; l++)
         for (int k = 0; k < 65536 && !found; k++)
            if (fnv_raw(16'(k), 3'(l)) == '0) begin
               zero_key = 16'(k);
               zero_lvl = 3'(l);
               found    = 1'b1;
            end
      for (int k = 0; k < 65536; k++)
         if (fnv_raw(16'(k), zero_lvl) == 16'h0001) one_key = 16'(k);

      // different key landing in the same slot as key 0, level 0
      base_hash   = fnv_raw(16'h0000, 3'd0);
      if (base_hash == '0) base_hash = 16'd1;
      collide_key = 16'h0001;
      found       = 1'b0;
      for (int k = 1; k < 65536 && !found; k++) begin
         h = fnv_raw(16'(k), 3'd0);
         if (h != '0 && h != base_hash && (h % NUM_SLOTS) == (base_hash % NUM_SLOTS)) begin
            collide_key = 16'(k);
            found       = 1'b1;
         end
      end

      // empty table, then extremes and a wrapping score total
      row(mk_req(hbst_pkg::CMD_LOOKUP, 16'h0000, 3'd0, 32'h0, 16'h0, 1'b0), 1'b1,
          mk_res(1'b0, 32'h0, 16'h0, 8'h00, 32'd0, 32'h0));
      row(mk_req(hbst_pkg::CMD_RECORD, 16'h0000, 3'd0, 32'hffff_ffff, 16'hffff, 1'b1), 1'b1,
          mk_res(1'b1, 32'hffff_ffff, 16'hffff, 8'h01, 32'd1, 32'hffff_ffff));
      row(mk_req(hbst_pkg::CMD_LOOKUP, 16'h0000, 3'd0, 32'h1234_5678, 16'h9abc, 1'b1), 1'b1,
          mk_res(1'b1, 32'hffff_ffff, 16'hffff, 8'h01, 32'd1, 32'hffff_ffff));
      row(mk_req(hbst_pkg::CMD_RECORD, 16'h0000, 3'd0, 32'h1, 16'h0, 1'b0), 1'b1,
          mk_res(1'b1, 32'hffff_ffff, 16'hffff, 8'h01, 32'd2, 32'h0));
      row(mk_req(hbst_pkg::CMD_RECORD, 16'hffff, 3'd7, 32'h0, 16'h0, 1'b1), 1'b1,
          mk_res(1'b1, 32'h0, 16'h0, 8'h80, 32'd3, 32'h0));
      row(mk_req(hbst_pkg::CMD_LOOKUP, 16'hffff, 3'd7, 32'h0, 16'h0, 1'b0), 1'b1,
          mk_res(1'b1, 32'h0, 16'h0, 8'h80, 32'd3, 32'h0));
      // max tracking of score and combo separately
      row(mk_req(hbst_pkg::CMD_RECORD, 16'hffff, 3'd7, 32'h8000_0000, 16'h8000, 1'b0),
          1'b0, '0);
      row(mk_req(hbst_pkg::CMD_RECORD, 16'hffff, 3'd7, 32'h1, 16'hffff, 1'b1), 1'b0, '0);
      // same key at another level is another entry
      row(mk_req(hbst_pkg::CMD_LOOKUP, 16'h0000, 3'd7, 32'h0, 16'h0, 1'b0), 1'b0, '0);
      row(mk_req(hbst_pkg::CMD_RECORD, 16'h00ff, 3'd3, 32'h5, 16'h7, 1'b1), 1'b0, '0);
      row(mk_req(hbst_pkg::CMD_LOOKUP, 16'hff00, 3'd3, 32'h0, 16'h0, 1'b0), 1'b0, '0);
      row(mk_req(hbst_pkg::CMD_LOOKUP, 16'h00ff, 3'd4, 32'h0, 16'h0, 1'b0), 1'b0, '0);
      // zero hash folded onto one, aliasing a genuine hash of one
      row(mk_req(hbst_pkg::CMD_RECORD, zero_key, zero_lvl, 32'h0000_0100, 16'h0010, 1'b1),
          1'b0, '0);
      row(mk_req(hbst_pkg::CMD_LOOKUP, zero_key, zero_lvl, 32'h0, 16'h0, 1'b0), 1'b0, '0);
      row(mk_req(hbst_pkg::CMD_LOOKUP, one_key, zero_lvl, 32'h0, 16'h0, 1'b0), 1'b0, '0);
      row(mk_req(hbst_pkg::CMD_RECORD, one_key, zero_lvl, 32'h0000_0200, 16'h0008, 1'b0),
          1'b0, '0);
      // eviction by a colliding key
      row(mk_req(hbst_pkg::CMD_RECORD, collide_key, 3'd0, 32'h0000_0042, 16'h0042, 1'b0),
          1'b0, '0);
      row(mk_req(hbst_pkg::CMD_LOOKUP, 16'h0000, 3'd0, 32'h0, 16'h0, 1'b0), 1'b0, '0);
      row(mk_req(hbst_pkg::CMD_LOOKUP, collide_key, 3'd0, 32'h0, 16'h0, 1'b0), 1'b0, '0);
      // alternating bit patterns
      row(mk_req(hbst_pkg::CMD_RECORD, 16'h5a5a, 3'd5, 32'haaaa_aaaa, 16'h5555, 1'b0),
          1'b0, '0);
      row(mk_req(hbst_pkg::CMD_RECORD, 16'ha5a5, 3'd2, 32'h5555_5555, 16'haaaa, 1'b1),
          1'b0, '0);
      row(mk_req(hbst_pkg::CMD_LOOKUP, 16'h1234, 3'd6, 32'h0, 16'h0, 1'b0), 1'b0, '0);

      // hold synchronous reset, then release it
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      // random traffic under each idle pattern
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin req_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
      end

      // receiver holds off while the sender keeps offering: the block backs up
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b1;
      repeat (PRESSURE_ITEMS) send_request(random_request(), 1'b0, '0);

      // sender pauses until everything is back, then a mixed tail
      idle_and_drain();
      req_idle_pct  = 36;
      rsp_stall_pct = 36;
      repeat (TAIL_ITEMS) send_request(random_request(), 1'b0, '0);

      idle_and_drain();
      repeat (DRAIN_CYC) @(posedge clock);

      $display("Ran %0d records and %0d lookups (%0d lookup hits), %0d results checked,",
               records_sent, lookups_sent, lookup_hits, results_checked);
      $display("with zero-hash aliasing, slot evictions, long output hold and idle mixes.");
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYC * 2 * CLK_HALF);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
